>>> rtl/hslrgb_pkg.sv
`timescale 1ns / 1ps

package hslrgb_pkg;

    // Field widths of one colour on each side.
    localparam int HUE_W  = 16;
    localparam int UNIT_W = 12;
    localparam int BYTE_W = 8;

    // Clamped saturation and lightness run from 0 to 1024, where 1024 is 1.0.
    localparam int            CLAMP_W  = 11;
    localparam logic [10:0]   UNIT_ONE = 11'd1024;

    // Hue steps: 1/16 degree, 960 steps per 60 degree sector.
    localparam logic [12:0]   HUE_SECTOR = 13'd960;

    // Every channel is carried over the denominator 960 * 2^20.
    localparam int            VAL_W = 30;
    localparam logic [29:0]   DENOM = 30'd1006632960;

    // The six sector arrangements of chroma, intermediate and zero.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } t_sector;

    // Load enables of the two channel stages.
    typedef struct packed {
        logic load_scale;
        logic load_byte;
    } t_chan_ctl;

    // Clamp a signed unit value into 0..1024.
    function automatic logic [10:0] clamp_unit(input logic signed [11:0] v);
        logic [10:0] res;
        if (v[11]) begin
            res = '0;
        end else if (v > 12'sd1024) begin
            res = UNIT_ONE;
        end else begin
            res = v[10:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/hslrgb_ifs.sv
`timescale 1ns / 1ps

// Request channel carrying one HSL colour.
interface hslrgb_hsl_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [hslrgb_pkg::HUE_W-1:0]      hue;
    logic signed [hslrgb_pkg::UNIT_W-1:0]     saturation;
    logic signed [hslrgb_pkg::UNIT_W-1:0]     lightness;

    modport source (output valid, hue, saturation, lightness, input ready);
    modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

// Result channel carrying one RGB colour.
interface hslrgb_rgb_if;
    logic                              valid;
    logic                              ready;
    logic [hslrgb_pkg::BYTE_W-1:0]     red;
    logic [hslrgb_pkg::BYTE_W-1:0]     green;
    logic [hslrgb_pkg::BYTE_W-1:0]     blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hslrgb_chan.sv
`timescale 1ns / 1ps

// One output channel: offset add, clamp, and rounding of v * 255 / D to a byte.
// round(v*255/D) = floor((510v + D) / (2D)), with 2D = 15 * 2^27.
module hslrgb_chan (
    input  logic                              i_clk,
    input  hslrgb_pkg::t_chan_ctl             i_ctl,
    input  logic [hslrgb_pkg::VAL_W-1:0]      i_sel,
    input  logic [hslrgb_pkg::VAL_W-1:0]      i_ofs,
    output logic [hslrgb_pkg::BYTE_W-1:0]     o_byte
);

    localparam logic [12:0] RECIP_15 = 13'd4370;   // ceil(2^16 / 15)

    logic [30:0] sum;
    logic [29:0] val;
    logic [39:0] scaled;
    logic [24:0] quot;
    logic [11:0] r_scaled;
    logic [7:0]  r_byte;

    always_comb begin
        sum    = 31'(i_sel) + 31'(i_ofs);
        val    = (sum > 31'(hslrgb_pkg::DENOM)) ? hslrgb_pkg::DENOM : sum[29:0];
        scaled = (40'(val) << 9) - (40'(val) << 1) + 40'(hslrgb_pkg::DENOM);
        quot   = 25'(r_scaled) * 25'(RECIP_15);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_scale) begin
            r_scaled <= scaled[38:27];
        end
        if (i_ctl.load_byte) begin
            r_byte <= quot[23:16];
        end
    end

    assign o_byte = r_byte;

endmodule

>>> rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// HSL to RGB colour converter, six register stages deep.
// A request moves through the stage 1 to 6 registers in order, and its
// result is offered from the stage 6 registers.
// Throughput: one colour per cycle; each stage moves on when it is empty or
// its successor moves, so a stalled output only holds back occupied stages.
// Reset clears the stage valid bits only; the data registers are not reset.
module hsl_to_rgb_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hslrgb_hsl_if.sink            i_hsl,
    hslrgb_rgb_if.source          o_rgb
);

    // The hue is biased to unsigned by flipping its sign bit, which adds 32768.
    // 32768 mod 5760 is 3968, so adding a further 1792 makes the biased value
    // congruent to the true hue modulo 5760. Since 5760 = 45 * 128, the
    // remainder is (a mod 45) * 128 plus the low seven bits, with a = v >> 7.
    localparam logic [16:0] HUE_BIAS  = 17'd1792;
    localparam logic [10:0] RECIP_45  = 11'd1457;   // ceil(2^16 / 45)
    localparam logic [9:0]  DIV_45    = 10'd45;

    // Stage valid bits and per-stage advance enables.
    logic [6:1] r_vld;
    logic [7:1] en;

    always_comb begin
        en[7] = o_rgb.ready;
        en[6] = !r_vld[6] || en[7];
        en[5] = !r_vld[5] || en[6];
        en[4] = !r_vld[4] || en[5];
        en[3] = !r_vld[3] || en[4];
        en[2] = !r_vld[2] || en[3];
        en[1] = !r_vld[1] || en[2];
    end

    assign i_hsl.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_hsl.valid;
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3];
            if (en[5]) r_vld[5] <= r_vld[4];
            if (en[6]) r_vld[6] <= r_vld[5];
        end
    end

    // Stage 1: bias the hue, estimate its quotient by 45 * 128, clamp S and L.
    logic [16:0] hue_biased;
    logic [9:0]  hue_hi;
    logic [19:0] quot_prod;
    logic [9:0]  r1_hue_hi;
    logic [6:0]  r1_hue_lo;
    logic [3:0]  r1_quot;
    logic [10:0] r1_sat;
    logic [10:0] r1_lit;

    always_comb begin
        hue_biased = {1'b0, ~i_hsl.hue[15], i_hsl.hue[14:0]} + HUE_BIAS;
        hue_hi     = hue_biased[16:7];
        quot_prod  = 20'(hue_hi) * 20'(RECIP_45);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_hue_hi <= hue_hi;
            r1_hue_lo <= hue_biased[6:0];
            r1_quot   <= quot_prod[19:16];
            r1_sat    <= hslrgb_pkg::clamp_unit(i_hsl.saturation);
            r1_lit    <= hslrgb_pkg::clamp_unit(i_hsl.lightness);
        end
    end

    // Stage 2: finish the hue reduction and form chroma = (1 - |2L - 1|) * S,
    // scaled by 2^20.
    logic [9:0]  hue_rem;
    logic [11:0] lit_dbl;
    logic [11:0] lit_dev;
    logic [10:0] lit_span;
    logic [20:0] chroma;
    logic [12:0] r2_hue;
    logic [20:0] r2_chroma;
    logic [10:0] r2_lit;

    always_comb begin
        hue_rem  = r1_hue_hi - 10'(r1_quot) * DIV_45;
        lit_dbl  = {r1_lit, 1'b0};
        lit_dev  = (lit_dbl >= 12'(hslrgb_pkg::UNIT_ONE))
                 ? lit_dbl - 12'(hslrgb_pkg::UNIT_ONE)
                 : 12'(hslrgb_pkg::UNIT_ONE) - lit_dbl;
        lit_span = 11'(12'(hslrgb_pkg::UNIT_ONE) - lit_dev);
        chroma   = 21'(lit_span) * 21'(r1_sat);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_hue    <= {hue_rem[5:0], r1_hue_lo};
            r2_chroma <= chroma;
            r2_lit    <= r1_lit;
        end
    end

    // Stage 3: find the sector and the position within the 120 degree span.
    // The intermediate factor is 960 - |pos - 960|. Chroma and the lightness
    // offset m = L - C/2 are brought onto the common denominator here.
    hslrgb_pkg::t_sector sector;
    logic [12:0] span_base;
    logic [10:0] span_pos;
    logic [9:0]  x_factor;
    logic [29:0] chroma_full;
    logic [29:0] offset;
    hslrgb_pkg::t_sector r3_sector;
    logic [9:0]  r3_x_factor;
    logic [20:0] r3_chroma;
    logic [29:0] r3_c;
    logic [29:0] r3_m;

    always_comb begin
        if (r2_hue >= 5 * hslrgb_pkg::HUE_SECTOR) begin
            sector = hslrgb_pkg::SEC_MAGENTA_RED;
        end else if (r2_hue >= 4 * hslrgb_pkg::HUE_SECTOR) begin
            sector = hslrgb_pkg::SEC_BLUE_MAGENTA;
        end else if (r2_hue >= 3 * hslrgb_pkg::HUE_SECTOR) begin
            sector = hslrgb_pkg::SEC_CYAN_BLUE;
        end else if (r2_hue >= 2 * hslrgb_pkg::HUE_SECTOR) begin
            sector = hslrgb_pkg::SEC_GREEN_CYAN;
        end else if (r2_hue >= hslrgb_pkg::HUE_SECTOR) begin
            sector = hslrgb_pkg::SEC_YELLOW_GREEN;
        end else begin
            sector = hslrgb_pkg::SEC_RED_YELLOW;
        end

        // Pairs of sectors share one 120 degree span.
        span_base = 13'(sector[2:1]) * 13'(2 * hslrgb_pkg::HUE_SECTOR);
        span_pos  = 11'(r2_hue - span_base);
        x_factor  = (span_pos < 11'(hslrgb_pkg::HUE_SECTOR))
                  ? span_pos[9:0]
                  : 10'(11'(2 * hslrgb_pkg::HUE_SECTOR) - span_pos);

        // 960 = 1024 - 64 and 480 = 512 - 32, so only shifts and adds.
        chroma_full = (30'(r2_chroma) << 10) - (30'(r2_chroma) << 6);
        offset      = ((30'(r2_lit) << 20) - (30'(r2_lit) << 16))
                    - ((30'(r2_chroma) << 9) - (30'(r2_chroma) << 5));
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_sector   <= sector;
            r3_x_factor <= x_factor;
            r3_chroma   <= r2_chroma;
            r3_c        <= chroma_full;
            r3_m        <= offset;
        end
    end

    // Stage 4: intermediate value x = chroma * factor, which never exceeds
    // the common denominator and so fits in 30 bits.
    logic [29:0] x_prod;
    hslrgb_pkg::t_sector r4_sector;
    logic [29:0] r4_x;
    logic [29:0] r4_c;
    logic [29:0] r4_m;

    assign x_prod = 30'(r3_chroma) * 30'(r3_x_factor);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_sector <= r3_sector;
            r4_x      <= x_prod;
            r4_c      <= r3_c;
            r4_m      <= r3_m;
        end
    end

    // Sector arrangement of (c, x, 0) onto red, green and blue.
    logic [29:0] red_sel;
    logic [29:0] green_sel;
    logic [29:0] blue_sel;

    always_comb begin
        unique case (r4_sector)
            hslrgb_pkg::SEC_RED_YELLOW: begin
                red_sel = r4_c; green_sel = r4_x; blue_sel = '0;
            end
            hslrgb_pkg::SEC_YELLOW_GREEN: begin
                red_sel = r4_x; green_sel = r4_c; blue_sel = '0;
            end
            hslrgb_pkg::SEC_GREEN_CYAN: begin
                red_sel = '0; green_sel = r4_c; blue_sel = r4_x;
            end
            hslrgb_pkg::SEC_CYAN_BLUE: begin
                red_sel = '0; green_sel = r4_x; blue_sel = r4_c;
            end
            hslrgb_pkg::SEC_BLUE_MAGENTA: begin
                red_sel = r4_x; green_sel = '0; blue_sel = r4_c;
            end
            default: begin
                red_sel = r4_c; green_sel = '0; blue_sel = r4_x;
            end
        endcase
    end

    // Stages 5 and 6 live in the channel units: offset, clamp and rounding.
    hslrgb_pkg::t_chan_ctl chan_ctl;

    always_comb begin
        chan_ctl.load_scale = en[5];
        chan_ctl.load_byte  = en[6];
    end

    hslrgb_chan u_red (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_sel  (red_sel),
        .i_ofs  (r4_m),
        .o_byte (o_rgb.red)
    );

    hslrgb_chan u_green (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_sel  (green_sel),
        .i_ofs  (r4_m),
        .o_byte (o_rgb.green)
    );

    hslrgb_chan u_blue (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_sel  (blue_sel),
        .i_ofs  (r4_m),
        .o_byte (o_rgb.blue)
    );

    assign o_rgb.valid = r_vld[6];

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the HSL to RGB colour converter.
//
// Every request that the converter accepts is run through a behavioural
// model of the conversion below, and the colour that it predicts is queued.
// Each colour that leaves the converter is compared, channel by channel,
// with the oldest colour in that queue. The converter holds no state, so
// the model is a pure function of the one request.
module tb;

    // Hue steps in one full turn and in one 60 degree sector, and the
    // fixed-point value of 1.0 for saturation and lightness.
    localparam longint HUE_TURN     = 5760;
    localparam longint SECTOR_STEPS = 960;
    localparam longint FULL_UNIT    = 1024;

    // Every channel is worked out over this common denominator, so the whole
    // conversion stays exact until the final rounding to a byte.
    localparam longint CHANNEL_DENOM = SECTOR_STEPS << 20;

    // Cycles to wait for stragglers once nothing is expected any more; well
    // beyond the six stages of the pipeline.
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [hslrgb_pkg::BYTE_W-1:0] red;
        logic [hslrgb_pkg::BYTE_W-1:0] green;
        logic [hslrgb_pkg::BYTE_W-1:0] blue;
    } t_rgb_colour;

    logic clk;
    logic rst_n;

    hslrgb_hsl_if hsl_bus ();
    hslrgb_rgb_if rgb_bus ();

    hsl_to_rgb_converter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_hsl   (hsl_bus),
        .o_rgb   (rgb_bus)
    );

    // Colours predicted for accepted requests, oldest first.
    t_rgb_colour pending_rgb[$];
    int          mismatch_count;

    // When clear, neither side of the converter idles or stalls.
    bit idle_on;
    int stall_left;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp a channel to [0, denominator] and round v * 255 / denominator to
    // the nearest code, with halves going up.
    function automatic logic [hslrgb_pkg::BYTE_W-1:0] scale_to_byte(input longint v);
        longint clipped;
        clipped = v;
        if (clipped < 0) begin
            clipped = 0;
        end else if (clipped > CHANNEL_DENOM) begin
            clipped = CHANNEL_DENOM;
        end
        return hslrgb_pkg::BYTE_W'((clipped * 510 + CHANNEL_DENOM) / (2 * CHANNEL_DENOM));
    endfunction

    function automatic t_rgb_colour predict_rgb(
        input logic signed [hslrgb_pkg::HUE_W-1:0]  hue,
        input logic signed [hslrgb_pkg::UNIT_W-1:0] saturation,
        input logic signed [hslrgb_pkg::UNIT_W-1:0] lightness
    );
        longint              h;
        longint              sat;
        longint              lit;
        longint              dev;
        longint              chroma;
        longint              c_full;
        longint              x_full;
        longint              offset;
        longint              pos;
        longint              r;
        longint              g;
        longint              b;
        hslrgb_pkg::t_sector sector;
        t_rgb_colour         colour;

        // Wrap the hue into one turn; negative angles come up from below.
        h = hue;
        h = h % HUE_TURN;
        if (h < 0) begin
            h = h + HUE_TURN;
        end

        sat = saturation;
        lit = lightness;
        if (sat < 0) sat = 0;
        if (sat > FULL_UNIT) sat = FULL_UNIT;
        if (lit < 0) lit = 0;
        if (lit > FULL_UNIT) lit = FULL_UNIT;

        // Chroma (1 - |2L - 1|) * S, here scaled by 2^20.
        dev = 2 * lit - FULL_UNIT;
        if (dev < 0) dev = -dev;
        chroma = (FULL_UNIT - dev) * sat;
        c_full = chroma * SECTOR_STEPS;

        // The intermediate falls off linearly from the middle of each
        // 120 degree span.
        pos = (h % (2 * SECTOR_STEPS)) - SECTOR_STEPS;
        if (pos < 0) pos = -pos;
        x_full = chroma * (SECTOR_STEPS - pos);

        // Lightness offset m = L - C / 2.
        offset = (lit << 10) * SECTOR_STEPS - chroma * (SECTOR_STEPS / 2);

        // A hue exactly on a sector boundary belongs to the sector that
        // starts there, which integer division gives for free.
        sector = hslrgb_pkg::t_sector'(h / SECTOR_STEPS);
        case (sector)
            hslrgb_pkg::SEC_RED_YELLOW: begin
                r = c_full; g = x_full; b = 0;
            end
            hslrgb_pkg::SEC_YELLOW_GREEN: begin
                r = x_full; g = c_full; b = 0;
            end
            hslrgb_pkg::SEC_GREEN_CYAN: begin
                r = 0; g = c_full; b = x_full;
            end
            hslrgb_pkg::SEC_CYAN_BLUE: begin
                r = 0; g = x_full; b = c_full;
            end
            hslrgb_pkg::SEC_BLUE_MAGENTA: begin
                r = x_full; g = 0; b = c_full;
            end
            default: begin
                r = c_full; g = 0; b = x_full;
            end
        endcase

        colour.red   = scale_to_byte(r + offset);
        colour.green = scale_to_byte(g + offset);
        colour.blue  = scale_to_byte(b + offset);
        return colour;
    endfunction

    // Append one predicted colour at the tail of the queue.
    task automatic queue_expected(input t_rgb_colour colour);
        pending_rgb.insert(pending_rgb.size(), colour);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_colour(input t_rgb_colour got);
        t_rgb_colour want;
        if (pending_rgb.size() == 0) begin
            report_mismatch($sformatf("colour %0d/%0d/%0d with no request outstanding",
                                      got.red, got.green, got.blue));
        end else begin
            want = pending_rgb.pop_front();
            if (got.red !== want.red) begin
                report_mismatch($sformatf("red got %0d, expected %0d",
                                          got.red, want.red));
            end
            if (got.green !== want.green) begin
                report_mismatch($sformatf("green got %0d, expected %0d",
                                          got.green, want.green));
            end
            if (got.blue !== want.blue) begin
                report_mismatch($sformatf("blue got %0d, expected %0d",
                                          got.blue, want.blue));
            end
        end
    endtask

    // Every value is sampled at the rising edge, before any assignment made
    // at that edge has landed, so the order of processes does not matter.
    always @(posedge clk) begin
        if (rst_n && rgb_bus.valid && rgb_bus.ready) begin
            check_colour({rgb_bus.red, rgb_bus.green, rgb_bus.blue});
        end
    end

    // The receiving side stalls at random while idling is enabled, and takes
    // every colour at once otherwise.
    always @(posedge clk) begin
        if (!idle_on) begin
            stall_left    <= 0;
            rgb_bus.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            rgb_bus.ready <= (stall_left == 1);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left    <= $urandom_range(1, 19);
            rgb_bus.ready <= 1'b0;
        end else begin
            rgb_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one request and hold it until the converter takes it. Valid is
    // left high on return so that back-to-back requests need no bubble; it
    // is only lowered when a gap is inserted or the sender pauses.
    task automatic send_hsl(
        input logic signed [hslrgb_pkg::HUE_W-1:0]  hue,
        input logic signed [hslrgb_pkg::UNIT_W-1:0] saturation,
        input logic signed [hslrgb_pkg::UNIT_W-1:0] lightness
    );
        if (idle_on && $urandom_range(0, 5) == 0) begin
            hsl_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        hsl_bus.valid      <= 1'b1;
        hsl_bus.hue        <= hue;
        hsl_bus.saturation <= saturation;
        hsl_bus.lightness  <= lightness;
        @(posedge clk);
        while (!hsl_bus.ready) @(posedge clk);
        queue_expected(predict_rgb(hue, saturation, lightness));
    endtask

    // Withdraw the request line and wait until every colour has come back.
    task automatic wait_for_results();
        hsl_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_rgb.size() != 0) @(posedge clk);
    endtask

    // Field extremes, every sector and its edges, hue wrapping in both
    // directions, clamping of saturation and lightness, and a grey whose
    // channels fall exactly halfway between two codes.
    task automatic test_directed_cases();
        int k;
        idle_on = 1'b0;
        for (k = 0; k < 6; k++) begin
            send_hsl(16'(k * SECTOR_STEPS), 12'sd1024, 12'sd512);
        end
        send_hsl(16'sd959, 12'sd1024, 12'sd512);
        send_hsl(16'sd5759, 12'sd1024, 12'sd512);
        send_hsl(16'sd480, 12'sd1024, 12'sd512);
        send_hsl(16'sd5760, 12'sd1024, 12'sd512);
        send_hsl(-16'sd1, 12'sd1024, 12'sd512);
        send_hsl(16'sh8000, 12'sd1024, 12'sd512);
        send_hsl(16'sd32767, 12'sd1024, 12'sd512);
        send_hsl(16'sd300, 12'sh800, 12'sd512);
        send_hsl(16'sd300, 12'sd2047, 12'sd512);
        send_hsl(16'sd300, -12'sd1, 12'sd512);
        send_hsl(16'sd300, 12'sd1025, 12'sd512);
        send_hsl(16'sd2000, 12'sd700, 12'sh800);
        send_hsl(16'sd2000, 12'sd700, 12'sd2047);
        send_hsl(16'sd2000, 12'sd700, 12'sd0);
        send_hsl(16'sd2000, 12'sd700, 12'sd1024);
        send_hsl(16'sd2000, 12'sd700, 12'sd1025);
        send_hsl(16'sd2000, 12'sd700, -12'sd1);
        send_hsl(16'sd0, 12'sd0, 12'sd512);
        wait_for_results();
    endtask

    // Any bit pattern at all in each field, with both sides idling at random.
    task automatic test_random_fields(input int count);
        int k;
        logic [31:0] bits;
        idle_on = 1'b1;
        for (k = 0; k < count; k++) begin
            bits = $urandom;
            send_hsl(bits[15:0], 12'($urandom), 12'($urandom));
        end
    endtask

    // Colours within the nominal ranges, where the arithmetic is exercised
    // across its whole span rather than pinned by clamping.
    task automatic test_nominal_colours(input int count);
        int k;
        idle_on = 1'b1;
        for (k = 0; k < count; k++) begin
            send_hsl(16'($urandom_range(0, HUE_TURN - 1)),
                     12'($urandom_range(0, FULL_UNIT)),
                     12'($urandom_range(0, FULL_UNIT)));
        end
    endtask

    // The sender stops until the pipeline has fully emptied, then carries on.
    task automatic test_drain_pause();
        test_nominal_colours(20);
        wait_for_results();
        test_random_fields(20);
    endtask

    // Back-to-back requests with neither side idling, so the pipeline runs
    // at one colour per cycle to the end of the run.
    task automatic test_full_rate(input int count);
        int k;
        idle_on = 1'b0;
        for (k = 0; k < count; k++) begin
            if (k % 2 == 0) begin
                send_hsl(16'($urandom), 12'($urandom), 12'($urandom));
            end else begin
                send_hsl(16'($urandom_range(0, HUE_TURN - 1)),
                         12'($urandom_range(0, FULL_UNIT)),
                         12'($urandom_range(0, FULL_UNIT)));
            end
        end
    endtask

    initial begin
        mismatch_count     = 0;
        idle_on            = 1'b0;
        stall_left         = 0;
        rst_n              = 1'b0;
        hsl_bus.valid      = 1'b0;
        hsl_bus.hue        = '0;
        hsl_bus.saturation = '0;
        hsl_bus.lightness  = '0;
        rgb_bus.ready      = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_fields(190);
        test_drain_pause();
        test_nominal_colours(150);
        test_full_rate(60);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // More than twenty times the slowest correct run, with every request
    // meeting the longest gaps and stalls.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
